// ===== hw/rtl/decimal_text_to_fixed_point_assert.svh =====
// Assertion macros for the decimal text to fixed point converter.
// Included by the RTL files that check their own logic; needs no package.
`ifndef DECIMAL_TEXT_TO_FIXED_POINT_ASSERT_SVH
`define DECIMAL_TEXT_TO_FIXED_POINT_ASSERT_SVH

`ifndef SYNTHESIS
// Implication checked at every rising edge outside reset.
`define DTTFP_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("dttfp assertion failed");
// Same, with the consequent checked in the cycle after the antecedent.
`define DTTFP_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("dttfp assertion failed");
`else
`define DTTFP_ASSERT(lbl, clk, rstn, prop)
`define DTTFP_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ===== hw/rtl/dttfp_pkg.sv =====
// Package for the decimal text to fixed point converter: widths, types,
// character codes and the fraction digit weight table. No dependencies.
`default_nettype none

package dttfp_pkg;

  localparam int unsigned CharW  = 8;
  localparam int unsigned IntW   = 31;
  localparam int unsigned FracW  = 32;
  localparam int unsigned ValueW = 64;
  localparam int unsigned CntW   = 4;

  // Fraction digits past this count add nothing
  localparam logic [CntW-1:0] FracDigits = 4'd10;

  typedef logic [CharW-1:0]         char_t;
  typedef logic signed [ValueW-1:0] fixed_t;

  localparam char_t CharNul   = 8'h00;
  localparam char_t CharZero  = 8'h30;
  localparam char_t CharNine  = 8'h39;
  localparam char_t CharPoint = 8'h2E;
  localparam char_t CharComma = 8'h2C;
  localparam char_t CharMinus = 8'h2D;

  localparam logic [IntW-1:0]  IntMax  = {IntW{1'b1}};
  localparam logic [FracW-1:0] FracMax = {FracW{1'b1}};

  // round(2^32 * 10^-k) for fraction digit k, counted from one
  function automatic logic [FracW-1:0] frac_weight(input logic [CntW-1:0] k);
    logic [FracW-1:0] w;
    case (k)
      4'd1:    w = 32'd429496730;
      4'd2:    w = 32'd42949673;
      4'd3:    w = 32'd4294967;
      4'd4:    w = 32'd429497;
      4'd5:    w = 32'd42950;
      4'd6:    w = 32'd4295;
      4'd7:    w = 32'd429;
      4'd8:    w = 32'd43;
      4'd9:    w = 32'd4;
      default: w = '0;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/decimal_text_to_fixed_point.sv =====
// Decimal text to fixed point: one ASCII character per cycle in, one signed
// Q31.32 value out per NUL. Depends on dttfp_pkg and the assert macros.
// A NUL waits in the input register; its result is then loaded into the result register.
// Throughput: one character per cycle; input stalls only while a NUL waits
// on a result that downstream has not yet taken.
// Reset (rst_ni low, asynchronous): both registers empty, parser at start.
`default_nettype none
`include "decimal_text_to_fixed_point_assert.svh"

module decimal_text_to_fixed_point (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_stall_o,
  input  dttfp_pkg::char_t     char_code_i,
  output logic                 out_valid_o,
  input  wire                  out_stall_i,
  output dttfp_pkg::fixed_t    value_o,
  output logic                 overflow_o
);
  import dttfp_pkg::*;

  // Input register
  logic  in_valid_q;
  char_t char_q;

  // Parser state
  logic             at_start_q, at_start_d;
  logic             negative_q, negative_d;
  logic             seen_point_q, seen_point_d;
  logic             stopped_q, stopped_d;
  logic             saturated_q, saturated_d;
  logic [IntW-1:0]  int_q, int_d;
  logic [FracW-1:0] frac_q, frac_d;
  logic [CntW-1:0]  frac_cnt_q, frac_cnt_d;

  // Result register
  logic   out_valid_q;
  fixed_t value_q, value_d;
  logic   overflow_q;

  logic              out_free;
  logic              advance;
  logic              is_nul;
  logic              is_digit;
  logic              is_point;
  logic [CharW-1:0]  digit_off;
  logic [3:0]        digit;
  logic [IntW+3:0]   int_prod;
  logic [CntW-1:0]   frac_k;
  logic [FracW+3:0]  frac_prod;
  logic [FracW+4:0]  frac_sum;
  logic [ValueW-1:0] mag;

  // Handshake: a NUL needs the result register, other characters do not
  assign is_nul     = (char_q == CharNul);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && (!is_nul || out_free);
  assign in_stall_o = in_valid_q && !advance;

  // Character classes and datapath terms
  assign is_digit  = char_q inside {[CharZero:CharNine]};
  assign is_point  = (char_q == CharPoint) || (char_q == CharComma);
  assign digit_off = char_q - CharZero;
  assign digit     = digit_off[3:0];
  assign int_prod  = {1'b0, int_q, 3'b000} + {3'b000, int_q, 1'b0}
                   + {{IntW{1'b0}}, digit};
  assign frac_k    = frac_cnt_q + 4'd1;
  assign frac_prod = {{FracW{1'b0}}, digit} * {4'd0, frac_weight(frac_k)};
  assign frac_sum  = {5'd0, frac_q} + {1'b0, frac_prod};
  assign mag       = {1'b0, int_q, frac_q};

  // Next parser state for the character in the input register
  always_comb begin
    at_start_d   = at_start_q;
    negative_d   = negative_q;
    seen_point_d = seen_point_q;
    stopped_d    = stopped_q;
    saturated_d  = saturated_q;
    int_d        = int_q;
    frac_d       = frac_q;
    frac_cnt_d   = frac_cnt_q;
    value_d      = negative_q ? fixed_t'(-mag) : fixed_t'(mag);

    if (is_nul) begin
      at_start_d   = 1'b1;
      negative_d   = 1'b0;
      seen_point_d = 1'b0;
      stopped_d    = 1'b0;
      saturated_d  = 1'b0;
      int_d        = '0;
      frac_d       = '0;
      frac_cnt_d   = '0;
    end else if (!stopped_q) begin
      at_start_d = 1'b0;
      if (at_start_q && char_q == CharMinus) begin
        negative_d = 1'b1;
      end else if (is_digit) begin
        if (!seen_point_q) begin
          if (saturated_q || int_prod > {4'd0, IntMax}) begin
            int_d       = IntMax;
            saturated_d = 1'b1;
          end else begin
            int_d = int_prod[IntW-1:0];
          end
        end else if (frac_cnt_q < FracDigits) begin
          frac_d     = (frac_sum > {5'd0, FracMax}) ? FracMax : frac_sum[FracW-1:0];
          frac_cnt_d = frac_k;
        end
      end else if (is_point && !seen_point_q) begin
        seen_point_d = 1'b1;
      end else begin
        stopped_d = 1'b1;
      end
    end
  end

  // Input register: refills on transfer, empties when its character moves on
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && !in_stall_o) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      char_q <= char_code_i;
    end
  end

  // Parser state update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      at_start_q   <= 1'b1;
      negative_q   <= 1'b0;
      seen_point_q <= 1'b0;
      stopped_q    <= 1'b0;
      saturated_q  <= 1'b0;
      int_q        <= '0;
      frac_q       <= '0;
      frac_cnt_q   <= '0;
    end else if (advance) begin
      at_start_q   <= at_start_d;
      negative_q   <= negative_d;
      seen_point_q <= seen_point_d;
      stopped_q    <= stopped_d;
      saturated_q  <= saturated_d;
      int_q        <= int_d;
      frac_q       <= frac_d;
      frac_cnt_q   <= frac_cnt_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && is_nul) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && is_nul) begin
      value_q    <= value_d;
      overflow_q <= saturated_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;
  assign overflow_o  = overflow_q;

  // Checks on internal consistency
  `DTTFP_ASSERT(a_stall_only_on_full, clk_i, rst_ni,
      in_stall_o |-> (is_nul && out_valid_q && out_stall_i))
  `DTTFP_ASSERT(a_sat_holds_max, clk_i, rst_ni,
      saturated_q |-> (int_q == IntMax))
  `DTTFP_ASSERT(a_frac_cnt_bound, clk_i, rst_ni,
      frac_cnt_q <= FracDigits)
  `DTTFP_ASSERT(a_no_frac_before_point, clk_i, rst_ni,
      !seen_point_q |-> (frac_cnt_q == '0 && frac_q == '0))
  `DTTFP_ASSERT_NEXT(a_nul_restarts, clk_i, rst_ni,
      advance && is_nul, at_start_q && !negative_q && !saturated_q && out_valid_q)

endmodule

`default_nettype wire
